>>> src/etcg_pkg.sv
// shared types, constants and tables for the encoder tempo clock generator
`default_nettype none

package etcg_pkg;

    localparam int TEMPO_W = 10;
    localparam int NUMER_W = 16;
    localparam int TIMER_W = 8;
    localparam int DIGIT_W = 4;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [TEMPO_W-1:0] TEMPO_MAX = 10'd800;
    localparam logic [TEMPO_W-1:0] TEMPO_MIN = 10'd30;
    localparam logic [TEMPO_W-1:0] TEMPO_DEFAULT = 10'd120;

    localparam logic [TEMPO_W-1:0] RESET_START_TEMPO = 10'd120;
    localparam logic [NUMER_W-1:0] RESET_NUMERATOR = 16'd29297;
    localparam logic [TIMER_W-1:0] RESET_SETTLE = 8'd120;
    localparam logic [TIMER_W-1:0] RESET_MESSAGE = 8'd100;
    localparam logic [NUMER_W-1:0] RESET_PERIOD = NUMER_W'(29297 / 120);

    localparam int BEAT_DIVIDE_DEFAULT = 8;

    // restoring divider, one quotient bit per cycle
    localparam int DIV_STEPS = NUMER_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // decimal split by reciprocal multiply, exact for values below 1000
    localparam logic [15:0] HUND_MUL = 16'd41;
    localparam int HUND_SHIFT = 12;
    localparam logic [14:0] TENS_MUL = 15'd205;
    localparam int TENS_SHIFT = 11;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_START_TEMPO = 2'd0,
        CFG_NUMERATOR   = 2'd1,
        CFG_SETTLE      = 2'd2,
        CFG_MESSAGE     = 2'd3
    } cfg_reg_e;

    typedef enum logic [1:0] {
        STEP_NONE = 2'd0,
        STEP_DOWN = 2'd1,
        STEP_UP   = 2'd2,
        STEP_SKIP = 2'd3
    } step_e;

    // indexed by {last phases, new phases}
    localparam step_e STEP_TABLE [16] = '{
        STEP_NONE, STEP_DOWN, STEP_UP,   STEP_SKIP,
        STEP_UP,   STEP_NONE, STEP_SKIP, STEP_DOWN,
        STEP_DOWN, STEP_SKIP, STEP_NONE, STEP_UP,
        STEP_SKIP, STEP_UP,   STEP_DOWN, STEP_NONE
    };

    typedef struct packed {
        logic [1:0] encoder_phases;
        logic       slow_tick;
    } in_item_t;

    typedef struct packed {
        logic               fast_clock;
        logic               beat_clock;
        logic [DIGIT_W-1:0] digit_hundreds;
        logic [DIGIT_W-1:0] digit_tens;
        logic [DIGIT_W-1:0] digit_units;
        logic               save_strobe;
        logic [TEMPO_W-1:0] save_tempo;
        logic [TEMPO_W-1:0] tempo_now;
    } out_item_t;

    typedef struct packed {
        logic accept;
        logic div_load;
        logic div_step;
        logic clamp;
        logic dig_h;
        logic dig_r;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic restart_req;
        logic step_valid;
        logic out_free;
    } status_t;

    function automatic logic [TEMPO_W-1:0] check_start(input logic [TEMPO_W-1:0] value);
        logic [TEMPO_W-1:0] t;
        t = value;
        if (t > TEMPO_MAX) t = TEMPO_DEFAULT;
        if (t < TEMPO_MIN) t = TEMPO_MIN;
        return t;
    endfunction

endpackage

`default_nettype wire

>>> src/etcg_datapath.sv
// datapath: config registers, tick and tempo state, divider, digit split, result register
`default_nettype none

module etcg_datapath #(
    parameter int BEAT_DIVIDE = etcg_pkg::BEAT_DIVIDE_DEFAULT
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire etcg_pkg::in_item_t                  in_item,
    input  wire logic                                out_stall,
    output etcg_pkg::out_item_t                      out_item,
    output logic                                     out_valid,
    input  wire logic                                cfg_we,
    input  wire logic [etcg_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [etcg_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire etcg_pkg::cmd_t                      cmd,
    output etcg_pkg::status_t                        status
);
    import etcg_pkg::*;

    localparam int BEAT_W = $clog2(BEAT_DIVIDE);

    cfg_reg_e cfg_sel;

    logic [TEMPO_W-1:0] start_tempo_reg, start_tempo_next;
    logic [NUMER_W-1:0] numerator_reg, numerator_next;
    logic [TIMER_W-1:0] settle_ticks_reg, settle_ticks_next;
    logic [TIMER_W-1:0] message_ticks_reg, message_ticks_next;

    logic [1:0]         last_phases_reg, last_phases_next;
    logic [TEMPO_W-1:0] tempo_reg, tempo_next;
    logic [TEMPO_W-1:0] saved_reg, saved_next;
    logic [NUMER_W-1:0] period_reg, period_next;
    logic [NUMER_W-1:0] tick_reg, tick_next;
    logic               fast_reg, fast_next;
    logic [BEAT_W-1:0]  beat_cnt_reg, beat_cnt_next;
    logic               beat_reg, beat_next;
    logic [TIMER_W-1:0] settle_reg, settle_next;
    logic [TIMER_W-1:0] message_reg, message_next;
    logic [TEMPO_W-1:0] shown_reg, shown_next;
    logic               strobe_reg, strobe_next;
    logic [TEMPO_W-1:0] store_reg, store_next;
    logic               out_valid_reg, out_valid_next;

    logic [NUMER_W-1:0] quo_reg;
    logic [TEMPO_W-1:0] rem_reg;
    logic [DIGIT_W-1:0] hund_reg;
    logic [6:0]         rest_reg;
    out_item_t          out_reg;

    logic               restart_req;
    step_e              step_code;
    logic               step_valid;
    logic [TEMPO_W-1:0] stepped_tempo;
    logic [TEMPO_W-1:0] start_value;
    logic [TEMPO_W:0]   trial;
    logic [15:0]        hund_prod;
    logic [14:0]        tens_prod;
    logic [DIGIT_W-1:0] tens_digit;
    logic [DIGIT_W-1:0] units_digit;

    assign cfg_sel = cfg_reg_e'(cfg_index);
    assign restart_req = cfg_we && (cfg_sel == CFG_START_TEMPO || cfg_sel == CFG_NUMERATOR);

    // encoder decode against the last accepted position
    assign step_code = STEP_TABLE[{last_phases_reg, in_item.encoder_phases}];
    assign step_valid = (in_item.encoder_phases != last_phases_reg) && (step_code != STEP_SKIP);

    always_comb
    begin
        stepped_tempo = tempo_reg;
        case (step_code)
            STEP_UP:   if (tempo_reg < TEMPO_MAX) stepped_tempo = tempo_reg + 10'd1;
            STEP_DOWN: if (tempo_reg > TEMPO_MIN) stepped_tempo = tempo_reg - 10'd1;
            default:   stepped_tempo = tempo_reg;
        endcase
    end

    assign start_value = check_start((cfg_sel == CFG_START_TEMPO) ? cfg_data[TEMPO_W-1:0]
                                                                  : start_tempo_reg);

    assign status.restart_req = restart_req;
    assign status.step_valid  = step_valid;
    assign status.out_free    = !out_valid_reg || !out_stall;

    // config registers
    always_comb
    begin
        start_tempo_next   = start_tempo_reg;
        numerator_next     = numerator_reg;
        settle_ticks_next  = settle_ticks_reg;
        message_ticks_next = message_ticks_reg;
        if (cfg_we)
        begin
            unique case (cfg_sel)
                CFG_START_TEMPO: start_tempo_next   = cfg_data[TEMPO_W-1:0];
                CFG_NUMERATOR:   numerator_next     = cfg_data[NUMER_W-1:0];
                CFG_SETTLE:      settle_ticks_next  = cfg_data[TIMER_W-1:0];
                CFG_MESSAGE:     message_ticks_next = cfg_data[TIMER_W-1:0];
                default:         start_tempo_next   = start_tempo_reg;
            endcase
        end
    end

    // per item state update, restart and period clamp
    always_comb
    begin
        last_phases_next = last_phases_reg;
        tempo_next       = tempo_reg;
        saved_next       = saved_reg;
        period_next      = period_reg;
        tick_next        = tick_reg;
        fast_next        = fast_reg;
        beat_cnt_next    = beat_cnt_reg;
        beat_next        = beat_reg;
        settle_next      = settle_reg;
        message_next     = message_reg;
        shown_next       = shown_reg;
        strobe_next      = strobe_reg;
        store_next       = store_reg;

        if (restart_req)
        begin
            last_phases_next = 2'd0;
            tempo_next       = start_value;
            saved_next       = start_value;
            shown_next       = start_value;
            tick_next        = '0;
            fast_next        = 1'b0;
            beat_cnt_next    = '0;
            beat_next        = 1'b0;
            settle_next      = '0;
            message_next     = '0;
        end
        else if (cmd.accept)
        begin
            // period match is checked before the counter advances
            if (tick_reg == period_reg)
            begin
                tick_next = '0;
                fast_next = !fast_reg;
                if (beat_cnt_reg == BEAT_W'(BEAT_DIVIDE - 1))
                begin
                    beat_cnt_next = '0;
                    beat_next     = !beat_reg;
                end
                else
                begin
                    beat_cnt_next = beat_cnt_reg + 1'b1;
                end
            end
            else
            begin
                tick_next = tick_reg + 16'd1;
            end

            strobe_next = 1'b0;
            store_next  = '0;
            if (in_item.slow_tick)
            begin
                if (settle_reg != '0) settle_next = settle_reg - 8'd1;
                if (message_reg != '0)
                begin
                    message_next = message_reg - 8'd1;
                    if (message_next == '0) shown_next = tempo_reg;
                end
                if (saved_reg != tempo_reg && settle_next == '0)
                begin
                    saved_next   = tempo_reg;
                    message_next = message_ticks_reg;
                    shown_next   = '0;
                    strobe_next  = 1'b1;
                    store_next   = tempo_reg;
                end
            end

            if (step_valid)
            begin
                tempo_next       = stepped_tempo;
                settle_next      = settle_ticks_reg;
                shown_next       = stepped_tempo;
                last_phases_next = in_item.encoder_phases;
            end
        end

        // new period in place; pull the counter back under it
        if (cmd.clamp)
        begin
            period_next = quo_reg;
            if (tick_reg > quo_reg) tick_next = quo_reg - 16'd1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.finish) out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall) out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_tempo_reg   <= RESET_START_TEMPO;
            numerator_reg     <= RESET_NUMERATOR;
            settle_ticks_reg  <= RESET_SETTLE;
            message_ticks_reg <= RESET_MESSAGE;
            last_phases_reg   <= 2'd0;
            tempo_reg         <= RESET_START_TEMPO;
            saved_reg         <= RESET_START_TEMPO;
            period_reg        <= RESET_PERIOD;
            tick_reg          <= '0;
            fast_reg          <= 1'b0;
            beat_cnt_reg      <= '0;
            beat_reg          <= 1'b0;
            settle_reg        <= '0;
            message_reg       <= '0;
            shown_reg         <= RESET_START_TEMPO;
            strobe_reg        <= 1'b0;
            store_reg         <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            start_tempo_reg   <= start_tempo_next;
            numerator_reg     <= numerator_next;
            settle_ticks_reg  <= settle_ticks_next;
            message_ticks_reg <= message_ticks_next;
            last_phases_reg   <= last_phases_next;
            tempo_reg         <= tempo_next;
            saved_reg         <= saved_next;
            period_reg        <= period_next;
            tick_reg          <= tick_next;
            fast_reg          <= fast_next;
            beat_cnt_reg      <= beat_cnt_next;
            beat_reg          <= beat_next;
            settle_reg        <= settle_next;
            message_reg       <= message_next;
            shown_reg         <= shown_next;
            strobe_reg        <= strobe_next;
            store_reg         <= store_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    // restoring division of the numerator by the tempo
    assign trial = {rem_reg, quo_reg[NUMER_W-1]};

    // decimal split of the shown value
    assign hund_prod   = 16'(shown_reg) * HUND_MUL;
    assign tens_prod   = 15'(rest_reg) * TENS_MUL;
    assign tens_digit  = tens_prod[TENS_SHIFT +: DIGIT_W];
    assign units_digit = DIGIT_W'(rest_reg - 7'(tens_digit) * 7'd10);

    always_ff @(posedge clk)
    begin
        if (cmd.div_load)
        begin
            quo_reg <= numerator_reg;
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            if (trial >= {1'b0, tempo_reg})
            begin
                rem_reg <= TEMPO_W'(trial - {1'b0, tempo_reg});
                quo_reg <= {quo_reg[NUMER_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[TEMPO_W-1:0];
                quo_reg <= {quo_reg[NUMER_W-2:0], 1'b0};
            end
        end

        if (cmd.dig_h) hund_reg <= hund_prod[HUND_SHIFT +: DIGIT_W];
        if (cmd.dig_r) rest_reg <= 7'(shown_reg - 10'(hund_reg) * 10'd100);

        if (cmd.finish)
        begin
            out_reg.fast_clock     <= fast_reg;
            out_reg.beat_clock     <= beat_reg;
            out_reg.digit_hundreds <= hund_reg;
            out_reg.digit_tens     <= tens_digit;
            out_reg.digit_units    <= units_digit;
            out_reg.save_strobe    <= strobe_reg;
            out_reg.save_tempo     <= store_reg;
            out_reg.tempo_now      <= tempo_reg;
        end
    end

    assign out_item  = out_reg;
    assign out_valid = out_valid_reg;

    a_tempo_range: assert property (@(posedge clk) disable iff (!rst_n)
        tempo_reg >= TEMPO_MIN && tempo_reg <= TEMPO_MAX)
        else $error("tempo left its clamp range");

    a_strobe_store: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg |-> store_reg >= TEMPO_MIN && store_reg <= TEMPO_MAX)
        else $error("save strobe without a valid tempo to store");

endmodule

`default_nettype wire

>>> src/etcg_ctrl.sv
// controller: sequences item update, tempo division, digit split and result hand-off
`default_nettype none

module etcg_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire etcg_pkg::status_t   status,
    output etcg_pkg::cmd_t           cmd
);
    import etcg_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_LOAD,
        ST_DIV_RUN,
        ST_CLAMP,
        ST_DIG_H,
        ST_DIG_R,
        ST_FINISH
    } state_t;

    state_t               state_reg;
    logic                 item_reg;
    logic [DIV_CNT_W-1:0] count_reg;
    logic                 accept;

    assign in_stall = (state_reg != ST_IDLE) || status.restart_req;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        cmd          = '0;
        cmd.accept   = accept;
        cmd.div_load = (state_reg == ST_DIV_LOAD);
        cmd.div_step = (state_reg == ST_DIV_RUN);
        cmd.clamp    = (state_reg == ST_CLAMP);
        cmd.dig_h    = (state_reg == ST_DIG_H);
        cmd.dig_r    = (state_reg == ST_DIG_R);
        cmd.finish   = (state_reg == ST_FINISH) && status.out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            item_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (status.restart_req)
                    begin
                        item_reg  <= 1'b0;
                        state_reg <= ST_DIV_LOAD;
                    end
                    else if (accept)
                    begin
                        item_reg  <= 1'b1;
                        state_reg <= status.step_valid ? ST_DIV_LOAD : ST_DIG_H;
                    end
                end
                ST_DIV_LOAD:
                begin
                    count_reg <= '0;
                    state_reg <= ST_DIV_RUN;
                end
                ST_DIV_RUN:
                begin
                    count_reg <= count_reg + 1'b1;
                    if (count_reg == DIV_CNT_W'(DIV_STEPS - 1)) state_reg <= ST_CLAMP;
                end
                ST_CLAMP:
                begin
                    // a restart has no result to deliver
                    state_reg <= item_reg ? ST_DIG_H : ST_IDLE;
                end
                ST_DIG_H:
                begin
                    state_reg <= ST_DIG_R;
                end
                ST_DIG_R:
                begin
                    state_reg <= ST_FINISH;
                end
                ST_FINISH:
                begin
                    if (status.out_free) state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV_RUN && count_reg == DIV_CNT_W'(DIV_STEPS - 1)
        |=> state_reg == ST_CLAMP)
        else $error("divider did not finish after its last step");

    a_plain_item: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !status.step_valid |=> state_reg == ST_DIG_H)
        else $error("item without tempo change did not go to digit split");

    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE && status.restart_req |=> state_reg == ST_DIV_LOAD && !item_reg)
        else $error("restart write did not start a period division");

endmodule

`default_nettype wire

>>> src/encoder_tempo_clock_generator_core.sv
// top level of the encoder tempo clock generator
//
// each input item is one prescaled base tick carrying the two encoder phases
// and the slow housekeeping flag; each item gives exactly one result item with
// the fast and beat clock levels, three display digits, the save strobe and
// the current tempo. both channels use valid/stall; an item moves at a rising
// edge with valid high and stall low.
// an item that leaves the tempo alone goes straight to the digit split and the
// hand-off; one with a valid encoder step first runs the restoring divider that
// finds the new period one quotient bit per cycle (16 steps), then clamps.
// the result sits in an output register; if the receiver stalls, the next item
// is still taken and worked until its own result is ready, then waits for the
// register to drain.
// after reset the block runs from the default registers at once (period 244).
// writing start_tempo or period_numerator restarts the state and re-runs the
// division: input is stalled until the division is done; other writes just store.
`default_nettype none

module encoder_tempo_clock_generator_core #(
    parameter int BEAT_DIVIDE = etcg_pkg::BEAT_DIVIDE_DEFAULT
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire etcg_pkg::in_item_t                  in_item,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output etcg_pkg::out_item_t                      out_item,
    input  wire logic                                cfg_we,
    input  wire logic [etcg_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [etcg_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import etcg_pkg::*;

    cmd_t    cmd;
    status_t status;

    etcg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    etcg_datapath #(
        .BEAT_DIVIDE (BEAT_DIVIDE)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_item),
        .out_stall (out_stall),
        .out_item  (out_item),
        .out_valid (out_valid),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

`default_nettype wire

>>> verif/encoder_tempo_clock_generator_core_tb.sv
// testbench for the encoder tempo clock generator: directed and random base ticks, self-checking
`default_nettype none

module encoder_tempo_clock_generator_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import etcg_pkg::*;

    localparam int BEAT_DIV = 8;
    localparam int QUIET_LIMIT = 5000;
    localparam int NUM_PHASES = 8;
    localparam int ITEMS_PER_PHASE = 220;
    localparam int MAX_PRINTS = 40;

    // position of each phase pair along the quadrature ring, also its own inverse
    localparam logic [1:0] RING [4] = '{2'd0, 2'd1, 2'd3, 2'd2};

    logic clk;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    in_item_t in_item = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    out_item_t out_item;
    logic cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    encoder_tempo_clock_generator_core #(
        .BEAT_DIVIDE(BEAT_DIV)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_item(in_item),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_item(out_item),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // register copies
    logic [TEMPO_W-1:0] reg_start_tempo = RESET_START_TEMPO;
    logic [NUMER_W-1:0] reg_numerator = RESET_NUMERATOR;
    logic [TIMER_W-1:0] reg_settle = RESET_SETTLE;
    logic [TIMER_W-1:0] reg_message = RESET_MESSAGE;

    // tempo clock state
    logic [1:0]         phase_prev;
    logic [TEMPO_W-1:0] tempo_bpm;
    logic [TEMPO_W-1:0] kept_bpm;
    logic [NUMER_W-1:0] match_period;
    logic [NUMER_W-1:0] tick_counter;
    logic               fast_lvl;
    logic               beat_lvl;
    int                 beat_div_count;
    logic [TIMER_W-1:0] settle_wait;
    logic [TIMER_W-1:0] message_wait;
    logic [TEMPO_W-1:0] panel_value;

    out_item_t tick_results_q [$];
    int mismatch_count = 0;
    int results_seen = 0;
    int quiet_cycles = 0;
    int burst_left = 0;
    int random_sent = 0;
    int stall_cycle = 0;

    function automatic void retune_period();
        match_period = reg_numerator / NUMER_W'(tempo_bpm);
        if (tick_counter > match_period)
            tick_counter = match_period - 16'd1;
        panel_value = tempo_bpm;
    endfunction

    function automatic void restart_tempo_clock();
        phase_prev = 2'd0;
        tempo_bpm = reg_start_tempo;
        if (tempo_bpm > TEMPO_MAX)
            tempo_bpm = TEMPO_DEFAULT;
        if (tempo_bpm < TEMPO_MIN)
            tempo_bpm = TEMPO_MIN;
        kept_bpm = tempo_bpm;
        tick_counter = '0;
        fast_lvl = 1'b0;
        beat_div_count = 0;
        beat_lvl = 1'b0;
        settle_wait = '0;
        message_wait = '0;
        retune_period();
    endfunction

    function automatic step_e encoder_move(logic [1:0] from, logic [1:0] to);
        logic [1:0] delta;
        delta = RING[to] - RING[from];
        case (delta)
            2'd0: return STEP_NONE;
            2'd1: return STEP_DOWN;
            2'd3: return STEP_UP;
            default: return STEP_SKIP;
        endcase
    endfunction

    function automatic out_item_t advance_tempo_tick(in_item_t tick);
        out_item_t r;
        step_e mv;
        r = '0;
        if (tick_counter == match_period)
        begin
            tick_counter = '0;
            fast_lvl = ~fast_lvl;
            beat_div_count++;
            if (beat_div_count >= BEAT_DIV)
            begin
                beat_div_count = 0;
                beat_lvl = ~beat_lvl;
            end
        end
        else
            tick_counter = tick_counter + 16'd1;

        if (tick.slow_tick)
        begin
            if (settle_wait > 0)
                settle_wait--;
            if (message_wait > 0)
            begin
                message_wait--;
                if (message_wait == 0)
                    panel_value = tempo_bpm;
            end
            if (kept_bpm != tempo_bpm && settle_wait == 0)
            begin
                kept_bpm = tempo_bpm;
                message_wait = reg_message;
                panel_value = '0;
                r.save_strobe = 1'b1;
                r.save_tempo = tempo_bpm;
            end
        end

        if (tick.encoder_phases != phase_prev)
        begin
            mv = encoder_move(phase_prev, tick.encoder_phases);
            // a two-position jump is dropped and the old phases are kept
            if (mv != STEP_SKIP)
            begin
                if (mv == STEP_DOWN && tempo_bpm > TEMPO_MIN)
                    tempo_bpm--;
                else if (mv == STEP_UP && tempo_bpm < TEMPO_MAX)
                    tempo_bpm++;
                settle_wait = reg_settle;
                retune_period();
                phase_prev = tick.encoder_phases;
            end
        end

        r.fast_clock = fast_lvl;
        r.beat_clock = beat_lvl;
        r.digit_hundreds = DIGIT_W'(panel_value / 100);
        r.digit_tens = DIGIT_W'((panel_value / 10) % 10);
        r.digit_units = DIGIT_W'(panel_value % 10);
        r.tempo_now = tempo_bpm;
        return r;
    endfunction

    task automatic flag_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS)
            $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    task automatic compare_tick(out_item_t got, out_item_t want);
        if (got.fast_clock !== want.fast_clock)
            flag_mismatch($sformatf("result %0d fast_clock %0b, want %0b",
                results_seen, got.fast_clock, want.fast_clock));
        if (got.beat_clock !== want.beat_clock)
            flag_mismatch($sformatf("result %0d beat_clock %0b, want %0b",
                results_seen, got.beat_clock, want.beat_clock));
        if (got.digit_hundreds !== want.digit_hundreds)
            flag_mismatch($sformatf("result %0d digit_hundreds %0d, want %0d",
                results_seen, got.digit_hundreds, want.digit_hundreds));
        if (got.digit_tens !== want.digit_tens)
            flag_mismatch($sformatf("result %0d digit_tens %0d, want %0d",
                results_seen, got.digit_tens, want.digit_tens));
        if (got.digit_units !== want.digit_units)
            flag_mismatch($sformatf("result %0d digit_units %0d, want %0d",
                results_seen, got.digit_units, want.digit_units));
        if (got.save_strobe !== want.save_strobe)
            flag_mismatch($sformatf("result %0d save_strobe %0b, want %0b",
                results_seen, got.save_strobe, want.save_strobe));
        if (got.save_tempo !== want.save_tempo)
            flag_mismatch($sformatf("result %0d save_tempo %0d, want %0d",
                results_seen, got.save_tempo, want.save_tempo));
        if (got.tempo_now !== want.tempo_now)
            flag_mismatch($sformatf("result %0d tempo_now %0d, want %0d",
                results_seen, got.tempo_now, want.tempo_now));
    endtask

    // result side: check each accepted item and stall on a rotating pattern
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (tick_results_q.size() == 0)
                    flag_mismatch($sformatf("result %0d with nothing pending", results_seen));
                else
                    compare_tick(out_item, tick_results_q.pop_front());
                results_seen++;
            end
            stall_cycle++;
            case ((stall_cycle / 256) % 4)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 99) < 30);
                2: out_stall <= ($urandom_range(0, 99) < 75);
                default: out_stall <= (stall_cycle % 5 != 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("[encoder_tempo_clock_generator_core] ERROR");
            $finish;
        end
    end

    task automatic send_tick(in_item_t tick);
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(80, 200)
                                                     : $urandom_range(1, 30);
        end
        burst_left--;
        in_valid <= 1'b1;
        in_item <= tick;
        do
            @(posedge clk);
        while (in_stall);
        tick_results_q.push_back(advance_tempo_tick(tick));
    endtask

    task automatic send_phases(logic [1:0] phases, logic slow);
        in_item_t tick;
        tick.encoder_phases = phases;
        tick.slow_tick = slow;
        send_tick(tick);
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (tick_results_q.size() != 0);
    endtask

    // write one register with junk in the unused upper bits, then let a restart settle
    task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] value);
        logic [CFG_DATA_W-1:0] data;
        wait_drain();
        data = CFG_DATA_W'($urandom());
        case (idx)
            CFG_START_TEMPO:
            begin
                data[TEMPO_W-1:0] = value[TEMPO_W-1:0];
                reg_start_tempo = value[TEMPO_W-1:0];
                restart_tempo_clock();
            end
            CFG_NUMERATOR:
            begin
                data = value;
                reg_numerator = value;
                restart_tempo_clock();
            end
            CFG_SETTLE:
            begin
                data[TIMER_W-1:0] = value[TIMER_W-1:0];
                reg_settle = value[TIMER_W-1:0];
            end
            default:
            begin
                data[TIMER_W-1:0] = value[TIMER_W-1:0];
                reg_message = value[TIMER_W-1:0];
            end
        endcase
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        repeat (24) @(posedge clk);
    endtask

    task automatic quiesce();
        wait_drain();
        repeat (4) @(posedge clk);
    endtask

    // every pair of old and new phases, steps both ways and two-position jumps
    task automatic test_encoder_walk();
        logic [1:0] walk [19] = '{2'd0, 2'd1, 2'd1, 2'd3, 2'd3, 2'd2, 2'd2, 2'd0, 2'd2, 2'd3,
                                  2'd1, 2'd0, 2'd3, 2'd1, 2'd2, 2'd3, 2'd0, 2'd2, 2'd1};
        for (int i = 0; i < 19; i++)
            send_phases(walk[i], i[0]);
    endtask

    task automatic test_tempo_limits();
        quiesce();
        write_reg(CFG_START_TEMPO, 16'd30);
        send_phases(2'd1, 1'b0);
        write_reg(CFG_START_TEMPO, 16'd800);
        send_phases(2'd2, 1'b1);
        write_reg(CFG_START_TEMPO, 16'd0);
        send_phases(2'd0, 1'b0);
        write_reg(CFG_START_TEMPO, 16'd1023);
        send_phases(2'd0, 1'b0);
    endtask

    task automatic test_zero_period();
        quiesce();
        write_reg(CFG_NUMERATOR, 16'd0);
        send_phases(2'd2, 1'b0);
        send_phases(2'd2, 1'b0);
        // shrinking the period to zero under a running count wraps the count
        quiesce();
        write_reg(CFG_START_TEMPO, 16'd31);
        write_reg(CFG_NUMERATOR, 16'd31);
        send_phases(2'd2, 1'b0);
        send_phases(2'd2, 1'b0);
    endtask

    task automatic test_save_message();
        quiesce();
        write_reg(CFG_START_TEMPO, 16'd120);
        write_reg(CFG_SETTLE, 16'd0);
        write_reg(CFG_MESSAGE, 16'd0);
        send_phases(2'd2, 1'b0);
        send_phases(2'd2, 1'b1);
        send_phases(2'd3, 1'b1);
        quiesce();
        write_reg(CFG_SETTLE, 16'd2);
        write_reg(CFG_MESSAGE, 16'd1);
        send_phases(2'd1, 1'b1);
        send_phases(2'd1, 1'b1);
        send_phases(2'd1, 1'b1);
    endtask

    // one run of encoder motion: a turn, a rest, noise or a jump then a turn
    task automatic send_run(int slow_pct);
        int kind;
        int len;
        logic up;
        logic [1:0] pos;
        in_item_t tick;
        kind = $urandom_range(0, 99);
        len = $urandom_range(1, 12);
        up = 1'($urandom_range(0, 1));
        for (int k = 0; k < len; k++)
        begin
            tick.slow_tick = ($urandom_range(0, 99) < slow_pct);
            pos = RING[phase_prev] + (up ? 2'd3 : 2'd1);
            if (kind < 45)
                tick.encoder_phases = RING[pos];
            else if (kind < 80)
            begin
                tick.encoder_phases = phase_prev;
                tick.slow_tick = ($urandom_range(0, 99) < 70);
            end
            else if (kind < 92)
                tick.encoder_phases = 2'($urandom_range(0, 3));
            else
                tick.encoder_phases = (k == 0) ? ~phase_prev : RING[pos];
            send_tick(tick);
            random_sent++;
        end
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_timer();
        case ($urandom_range(0, 5))
            0: return 16'd0;
            1: return 16'd255;
            2: return 16'($urandom_range(0, 255));
            default: return 16'($urandom_range(0, 4));
        endcase
    endfunction

    task automatic test_random_traffic();
        logic [CFG_DATA_W-1:0] start_list [8] = '{16'd0, 16'd29, 16'd30, 16'd31,
                                                  16'd799, 16'd800, 16'd801, 16'd1023};
        logic [CFG_DATA_W-1:0] start_v;
        logic [CFG_DATA_W-1:0] numer_v;
        logic [CFG_DATA_W-1:0] settle_v;
        logic [CFG_DATA_W-1:0] message_v;
        int phase_goal;
        int slow_pct;
        bit paused;
        paused = 1'b0;
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            start_v = ($urandom_range(0, 1) == 1) ? start_list[$urandom_range(0, 7)]
                                                  : 16'($urandom_range(0, 1023));
            case ($urandom_range(0, 9))
                0: numer_v = 16'd0;
                1: numer_v = 16'd65535;
                2: numer_v = 16'($urandom());
                default: numer_v = 16'($urandom_range(1, 400));
            endcase
            settle_v = pick_timer();
            message_v = pick_timer();
            if (ph == 0)
            begin
                numer_v = 16'd65535;
                settle_v = 16'd1;
                message_v = 16'd255;
            end
            else if (ph == 1)
            begin
                numer_v = 16'd1;
                settle_v = 16'd255;
                message_v = 16'd1;
            end
            quiesce();
            write_reg(CFG_START_TEMPO, start_v);
            write_reg(CFG_NUMERATOR, numer_v);
            write_reg(CFG_SETTLE, settle_v);
            write_reg(CFG_MESSAGE, message_v);
            slow_pct = $urandom_range(10, 90);
            phase_goal = random_sent + ITEMS_PER_PHASE;
            while (random_sent < phase_goal)
            begin
                // hold the sender once until every pending result is out
                if (ph == 3 && !paused && random_sent >= phase_goal - ITEMS_PER_PHASE / 2)
                begin
                    wait_drain();
                    paused = 1'b1;
                end
                send_run(slow_pct);
            end
        end
    endtask

    initial
    begin
        restart_tempo_clock();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        test_encoder_walk();
        test_tempo_limits();
        test_zero_period();
        test_save_message();
        test_random_traffic();
        wait_drain();
        repeat (40) @(posedge clk);
        if (mismatch_count == 0)
            $display("[encoder_tempo_clock_generator_core] OK");
        else
            $display("[encoder_tempo_clock_generator_core] ERROR");
        $finish;
    end

endmodule

`default_nettype wire
